// ===== rtl/core/assert_macros.svh =====
// assert_macros.svh: assertion macros shared by the checker files.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked every clock, disabled during reset
`define PJQ_ASSERT_IMP(label, clk, rst, lhs, rhs, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
    else $error(msg);
// next-cycle implication, disabled during reset
`define PJQ_ASSERT_NEXT(label, clk, rst, lhs, rhs, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
    else $error(msg);
`endif

// ===== rtl/core/pjq_pkg.sv =====
// pjq_pkg: constants and types for the priority job queue.
// No dependencies.
package pjq_pkg;
  localparam int DEPTH_DEFAULT = 16;
  localparam int PRIO_W = 15;
  localparam int STAMP_W = 32;
  localparam int IDENT_W = 32;
  localparam int OCC_W = 5;
  localparam logic [15:0] PRIO_MAX = 16'd32767;

  typedef enum logic [1:0] {
    ST_OK = 2'd0, ST_BADPRIO = 2'd1, ST_FULL = 2'd2, ST_EMPTY = 2'd3
  } status_t;

  typedef enum logic {OP_PUSH = 1'b0, OP_POP = 1'b1} op_t;

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_SHIFT, S_DONE
  } state_t;

  typedef struct packed {
    logic [PRIO_W-1:0]  prio;
    logic [STAMP_W-1:0] stamp;
    logic [IDENT_W-1:0] ident;
  } job_t;

  // a (earlier slot) is served before b
  function automatic logic beats(job_t a, job_t b);
    logic r;
    if (a.prio != b.prio) r = a.prio > b.prio;
    else r = a.stamp <= b.stamp;
    return r;
  endfunction
endpackage

// ===== rtl/core/priority_job_queue.sv =====
// priority_job_queue: bounded priority queue of jobs with FIFO tie-break.
// Input channel in_valid/in_stall carries op, job_priority, job_stamp and
// job_ident. A push appends the job to slot count of a one-port-read memory
// (jobs kept in arrival order). A pop scans slots 0..count-1 one read per
// cycle to find the best job (highest priority, then smallest stamp, then
// earliest slot), then closes the gap by copying each later slot down one,
// again one memory read per cycle.
// Output channel out_valid/out_stall returns one transaction per input:
// status, popped job fields (zero unless a pop succeeded) and occupancy.
// A push or any error goes through S_DONE before out_valid rises. A pop
// scans the queued jobs in S_SCAN, compacts the slots after the winner in
// S_SHIFT, then finishes through S_DONE.
// One transaction is in flight at a time; in_stall is high while busy, so
// the next transaction can be taken while out_valid is high, if out_stall is low.
// The result sits in an output register; while out_stall is high it holds
// and no new input transaction is accepted.
// Reset (rst, synchronous) empties the queue; memory contents are left
// as they are, since only slots below the count are ever read.
module priority_job_queue #(
  parameter int DEPTH = pjq_pkg::DEPTH_DEFAULT,
  localparam int AW = $clog2(DEPTH),
  localparam int CW = $clog2(DEPTH + 1)
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        op,
  input  logic [15:0] job_priority,
  input  logic [31:0] job_stamp,
  input  logic [31:0] job_ident,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  status,
  output logic [31:0] out_ident,
  output logic [14:0] out_priority,
  output logic [31:0] out_stamp,
  output logic [4:0]  occupancy
);
  pjq_pkg::state_t state, state_next;
  logic [CW-1:0] count, count_next;
  logic [CW-1:0] idx, idx_next;      // read address counter
  logic [AW-1:0] best, best_next;
  pjq_pkg::job_t best_job, best_job_next;
  logic          rd_pend, rd_pend_next; // read issued last cycle
  logic [CW-1:0] rd_idx, rd_idx_next;   // slot that rdata belongs to
  logic          out_valid_next;
  pjq_pkg::status_t st_next;
  pjq_pkg::job_t res_job_next;

  logic          we;
  logic [AW-1:0] waddr, raddr;
  pjq_pkg::job_t wdata, rdata;
  logic          accept;

  pjq_mem #(.DEPTH(DEPTH)) u_mem (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
    .raddr(raddr), .rdata(rdata)
  );

  assign in_stall = (state != pjq_pkg::S_IDLE) || (out_valid && out_stall);
  assign accept   = in_valid && !in_stall;

  always_comb begin
    state_next    = state;
    count_next    = count;
    idx_next      = idx;
    best_next     = best;
    best_job_next = best_job;
    rd_pend_next  = 1'b0;
    rd_idx_next   = rd_idx;
    out_valid_next = out_valid && out_stall;
    st_next       = pjq_pkg::status_t'(status);
    res_job_next  = '{prio: out_priority, stamp: out_stamp, ident: out_ident};
    we    = 1'b0;
    waddr = count[AW-1:0];
    wdata = '{prio: job_priority[14:0], stamp: job_stamp, ident: job_ident};
    raddr = idx[AW-1:0];
    unique case (state)
      pjq_pkg::S_IDLE: begin
        if (accept) begin
          res_job_next = '0;
          state_next   = pjq_pkg::S_DONE;
          if (pjq_pkg::op_t'(op) == pjq_pkg::OP_PUSH) begin
            if (job_priority > pjq_pkg::PRIO_MAX) st_next = pjq_pkg::ST_BADPRIO;
            else if (count >= CW'(DEPTH)) st_next = pjq_pkg::ST_FULL;
            else begin
              st_next    = pjq_pkg::ST_OK;
              we         = 1'b1;
              count_next = count + 1'b1;
            end
          end else if (count == '0) begin
            st_next = pjq_pkg::ST_EMPTY;
          end else begin
            st_next      = pjq_pkg::ST_OK;
            raddr        = '0;
            rd_pend_next = 1'b1;
            rd_idx_next  = '0;
            idx_next     = CW'(1);
            state_next   = pjq_pkg::S_SCAN;
          end
        end
      end
      pjq_pkg::S_SCAN: begin
        // compare the slot that came back, issue the next read
        if (rd_pend) begin
          if (rd_idx == '0 || !pjq_pkg::beats(best_job, rdata)) begin
            best_job_next = rdata;
            best_next     = rd_idx[AW-1:0];
          end
        end
        if (idx < count) begin
          rd_pend_next = 1'b1;
          rd_idx_next  = idx;
          idx_next     = idx + 1'b1;
        end else if (!rd_pend) begin
          // scan done: start compaction at best+1
          res_job_next = best_job;
          idx_next     = CW'(best) + 1'b1;
          raddr        = AW'(CW'(best) + 1'b1);
          state_next   = pjq_pkg::S_SHIFT;
          if (CW'(best) + 1'b1 < count) begin
            rd_pend_next = 1'b1;
            rd_idx_next  = CW'(best) + 1'b1;
            idx_next     = CW'(best) + 2'd2;
          end
        end
      end
      pjq_pkg::S_SHIFT: begin
        if (rd_pend) begin
          we    = 1'b1;
          waddr = AW'(rd_idx - 1'b1);
          wdata = rdata;
        end
        if (idx < count) begin
          rd_pend_next = 1'b1;
          rd_idx_next  = idx;
          idx_next     = idx + 1'b1;
        end else if (!rd_pend) begin
          count_next = count - 1'b1;
          state_next = pjq_pkg::S_DONE;
        end
      end
      pjq_pkg::S_DONE: begin
        out_valid_next = 1'b1;
        state_next     = pjq_pkg::S_IDLE;
      end
      default: state_next = pjq_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= pjq_pkg::S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
      rd_pend   <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      out_valid <= out_valid_next;
      rd_pend   <= rd_pend_next;
    end
  end

  always_ff @(posedge clk) begin
    idx      <= idx_next;
    best     <= best_next;
    best_job <= best_job_next;
    rd_idx   <= rd_idx_next;
    if (!(out_valid && out_stall)) begin
      status       <= st_next;
      out_priority <= res_job_next.prio;
      out_stamp    <= res_job_next.stamp;
      out_ident    <= res_job_next.ident;
      occupancy    <= 5'(count_next);
    end
  end
endmodule

// ===== rtl/core/pjq_mem.sv =====
// pjq_mem: job store, one write port and one registered read port.
// Depends on pjq_pkg.
module pjq_mem #(
  parameter int DEPTH = pjq_pkg::DEPTH_DEFAULT,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic           clk,
  input  logic           we,
  input  logic [AW-1:0]  waddr,
  input  pjq_pkg::job_t  wdata,
  input  logic [AW-1:0]  raddr,
  output pjq_pkg::job_t  rdata
);
  pjq_pkg::job_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// ===== rtl/core/pjq_checker.sv =====
// pjq_checker: port-level assertions for priority_job_queue, with bind.
// Depends on assert_macros.svh and pjq_pkg.
`include "assert_macros.svh"
module pjq_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [1:0]  status,
  input logic [31:0] out_ident,
  input logic [14:0] out_priority,
  input logic [31:0] out_stamp,
  input logic [4:0]  occupancy
);
  logic       out_held, in_take, res_err, res_empty, res_blank;
  logic [6:0] res_tag;

  assign out_held  = out_valid && out_stall;
  assign in_take   = in_valid && !in_stall;
  assign res_err   = out_valid && (status != pjq_pkg::ST_OK);
  assign res_empty = out_valid && (status == pjq_pkg::ST_EMPTY);
  assign res_blank = (out_ident == '0) && (out_priority == '0) && (out_stamp == '0);
  assign res_tag   = {status, occupancy};

  `PJQ_ASSERT_NEXT(a_hold, clk, rst, out_held, out_valid && $stable(res_tag), "stalled result changed")
  `PJQ_ASSERT_IMP(a_zero, clk, rst, res_err, res_blank, "error result carries job")
  `PJQ_ASSERT_IMP(a_empty, clk, rst, res_empty, occupancy == '0, "empty status with jobs queued")
  `PJQ_ASSERT_NEXT(a_one, clk, rst, in_take, !out_valid || out_stall, "result too early")
endmodule

bind priority_job_queue pjq_checker u_pjq_checker (.*);

// ===== tb/tb_priority_job_queue.sv =====
// tb_priority_job_queue: self-checking testbench for the priority job queue.
// Depends on pjq_pkg and priority_job_queue; drives directed rows, then random
// push/pop traffic, and checks every result against a behavioral queue model.
`timescale 1ns / 100ps

module tb_priority_job_queue;
  localparam int DEPTH = 16;
  localparam int RAND_ITEMS = 600;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic        op;
    logic [15:0] prio;
    logic [31:0] stamp;
    logic [31:0] ident;
  } request_t;

  typedef struct packed {
    logic [1:0]  st;
    logic [31:0] ident;
    logic [14:0] prio;
    logic [31:0] stamp;
    logic [4:0]  occ;
  } answer_t;

  // directed row: request plus an optional typed-in answer
  typedef struct {
    request_t req;
    bit       has_fixed;
    answer_t  fixed;
  } row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        op = 1'b0;
  logic [15:0] job_priority = '0;
  logic [31:0] job_stamp = '0;
  logic [31:0] job_ident = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  status;
  logic [31:0] out_ident;
  logic [14:0] out_priority;
  logic [31:0] out_stamp;
  logic [4:0]  occupancy;

  priority_job_queue #(.DEPTH(DEPTH)) u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .op(op), .job_priority(job_priority), .job_stamp(job_stamp),
    .job_ident(job_ident),
    .out_valid(out_valid), .out_stall(out_stall),
    .status(status), .out_ident(out_ident), .out_priority(out_priority),
    .out_stamp(out_stamp), .occupancy(occupancy)
  );

  always #10 clk = ~clk;

  // behavioral copy of the queue, jobs kept in arrival order
  pjq_pkg::job_t held_jobs[$];
  answer_t pending_answers[$];
  int      errors = 0;
  int      cycles = 0;
  bit      hold_off = 1'b0;   // long receiver stall requested by the sender

  function automatic answer_t schedule_job(request_t r);
    answer_t       a;
    pjq_pkg::job_t j;
    int            best;
    a = '0;
    a.st = pjq_pkg::ST_OK;
    if (r.op == pjq_pkg::OP_PUSH) begin
      if (r.prio > pjq_pkg::PRIO_MAX) a.st = pjq_pkg::ST_BADPRIO;
      else if (held_jobs.size() >= DEPTH) a.st = pjq_pkg::ST_FULL;
      else begin
        j.prio = r.prio[14:0];
        j.stamp = r.stamp;
        j.ident = r.ident;
        held_jobs.push_back(j);
      end
    end else if (held_jobs.size() == 0) begin
      a.st = pjq_pkg::ST_EMPTY;
    end else begin
      best = 0;
      for (int i = 1; i < held_jobs.size(); i++) begin
        // the earlier slot keeps the win on exact ties
        if (held_jobs[i].prio > held_jobs[best].prio ||
            (held_jobs[i].prio == held_jobs[best].prio &&
             held_jobs[i].stamp < held_jobs[best].stamp))
          best = i;
      end
      a.ident = held_jobs[best].ident;
      a.prio = held_jobs[best].prio;
      a.stamp = held_jobs[best].stamp;
      held_jobs.delete(best);
    end
    a.occ = 5'(held_jobs.size());
    return a;
  endfunction

  // cycle counter and timeout
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // result checker: sampled at the rising edge
  always @(posedge clk) begin
    answer_t got, want;
    if (!rst && out_valid && !out_stall) begin
      got = '{status, out_ident, out_priority, out_stamp, occupancy};
      if (pending_answers.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
      end else begin
        want = pending_answers.pop_front();
        if (got.st != want.st)
          $display("%0t: status exp %0d got %0d", $time, want.st, got.st);
        if (got.ident != want.ident)
          $display("%0t: ident exp %h got %h", $time, want.ident, got.ident);
        if (got.prio != want.prio)
          $display("%0t: priority exp %0d got %0d", $time, want.prio, got.prio);
        if (got.stamp != want.stamp)
          $display("%0t: stamp exp %h got %h", $time, want.stamp, got.stamp);
        if (got.occ != want.occ)
          $display("%0t: occupancy exp %0d got %0d", $time, want.occ, got.occ);
        if (got != want) errors++;
      end
    end
  end

  // receiver: random stalls, plus one long hold-off counted here
  initial begin
    int n;
    forever begin
      @(negedge clk);
      if (hold_off) begin
        out_stall <= 1'b1;
        for (n = 0; n < 120; n++) @(negedge clk);
        hold_off = 1'b0;
        out_stall <= 1'b0;
      end else if ($urandom_range(0, 3) == 0) begin
        out_stall <= 1'b1;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(1, 3);
        repeat (n - 1) @(negedge clk);
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // offer one transaction and wait until it is taken
  task automatic send_job(request_t r, bit has_fixed, answer_t fixed);
    answer_t a;
    op <= r.op;
    job_priority <= r.prio;
    job_stamp <= r.stamp;
    job_ident <= r.ident;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    a = schedule_job(r);
    if (has_fixed && a != fixed) begin
      $display("%0t: table row exp %h, predictor %h", $time, fixed, a);
      errors++;
    end
    pending_answers.push_back(a);
    @(negedge clk);
    // random gap; a valid kept high is never toggled within one step
    if ($urandom_range(0, 2) == 0) begin
      in_valid <= 1'b0;
      repeat (($urandom_range(0, 9) == 0) ? $urandom_range(5, 25) : $urandom_range(1, 3))
        @(negedge clk);
    end
  endtask

  function automatic request_t rand_request(int pop_pct);
    request_t r;
    r.op = ($urandom_range(0, 99) < pop_pct) ? pjq_pkg::OP_POP : pjq_pkg::OP_PUSH;
    case ($urandom_range(0, 9))
      0: r.prio = 16'($urandom_range(32768, 65535));   // rejected
      1, 2: r.prio = 16'($urandom_range(0, 3));         // many priority ties
      default: r.prio = 16'($urandom_range(0, 32767));
    endcase
    r.stamp = ($urandom_range(0, 2) == 0) ? 32'($urandom_range(0, 3)) : $urandom;
    r.ident = $urandom;
    return r;
  endfunction

  row_t    rows[$];
  answer_t none;

  function automatic row_t mk(logic o, logic [15:0] p, logic [31:0] s, logic [31:0] i,
                              bit f, answer_t a);
    row_t r;
    r.req = '{o, p, s, i};
    r.has_fixed = f;
    r.fixed = a;
    return r;
  endfunction

  initial begin
    request_t r;
    int mode;
    none = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed table: empty pop, bad priorities, extremes, ties
    rows.push_back(mk(pjq_pkg::OP_POP, 16'hFFFF, '1, '1, 1,
                      '{pjq_pkg::ST_EMPTY, 0, 0, 0, 0}));
    rows.push_back(mk(pjq_pkg::OP_PUSH, 16'h8000, 0, 1, 1,
                      '{pjq_pkg::ST_BADPRIO, 0, 0, 0, 0}));
    rows.push_back(mk(pjq_pkg::OP_PUSH, 16'hFFFF, '1, '1, 1,
                      '{pjq_pkg::ST_BADPRIO, 0, 0, 0, 0}));
    rows.push_back(mk(pjq_pkg::OP_PUSH, 16'd32767, '1, '1, 1,
                      '{pjq_pkg::ST_OK, 0, 0, 0, 1}));
    rows.push_back(mk(pjq_pkg::OP_POP, 0, 0, 0, 1,
                      '{pjq_pkg::ST_OK, '1, 15'h7FFF, '1, 0}));
    rows.push_back(mk(pjq_pkg::OP_PUSH, 0, 0, 0, 1, '{pjq_pkg::ST_OK, 0, 0, 0, 1}));
    rows.push_back(mk(pjq_pkg::OP_PUSH, 5, 9, 32'hA, 0, none));
    rows.push_back(mk(pjq_pkg::OP_PUSH, 5, 7, 32'hB, 0, none));  // same prio, smaller stamp
    rows.push_back(mk(pjq_pkg::OP_PUSH, 5, 7, 32'hC, 0, none));  // exact tie, later arrival
    rows.push_back(mk(pjq_pkg::OP_POP, 0, 0, 0, 0, none));
    rows.push_back(mk(pjq_pkg::OP_POP, 0, 0, 0, 0, none));
    rows.push_back(mk(pjq_pkg::OP_POP, 0, 0, 0, 0, none));
    rows.push_back(mk(pjq_pkg::OP_POP, 0, 0, 0, 1, '{pjq_pkg::ST_OK, 0, 0, 0, 0}));
    rows.push_back(mk(pjq_pkg::OP_POP, 0, 0, 0, 1, '{pjq_pkg::ST_EMPTY, 0, 0, 0, 0}));
    foreach (rows[k]) send_job(rows[k].req, rows[k].has_fixed, rows[k].fixed);

    // fill to full, then the full refusal and a bad priority on a full queue
    for (int k = 0; k < DEPTH; k++) begin
      r = '{pjq_pkg::OP_PUSH, 16'($urandom_range(0, 32767)), $urandom, $urandom};
      send_job(r, 0, none);
    end
    send_job('{pjq_pkg::OP_PUSH, 16'd1, 32'd1, 32'd1}, 1,
             '{pjq_pkg::ST_FULL, 0, 0, 0, 16});
    send_job('{pjq_pkg::OP_PUSH, 16'h8001, 32'd1, 32'd1}, 1,
             '{pjq_pkg::ST_BADPRIO, 0, 0, 0, 16});

    // random part in phases of differing push/pop mix; long receiver
    // hold-off early on so the sender backs up against the busy block
    for (int k = 0; k < RAND_ITEMS; k++) begin
      if (k == 20) hold_off = 1'b1;
      mode = (k / 100) % 3;
      r = rand_request(mode == 0 ? 30 : (mode == 1 ? 50 : 70));
      send_job(r, 0, none);
    end
    in_valid <= 1'b0;

    while (pending_answers.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    if (errors == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end
endmodule
